@@ rtl/pswrl_pkg.sv @@
package pswrl_pkg;

  // table geometry, sets must be a power of two (set index is the low address bits)
  localparam int TABLE_SETS = 256;
  localparam int TABLE_WAYS = 4;
  localparam int SET_W = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;
  localparam int WAY_W = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;

  localparam int ADDR_W  = 32;
  localparam int TIME_W  = 64;
  localparam int COUNT_W = 32;
  localparam int LIMIT_W = 32;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LIMIT = CFG_IDX_W'(1);

  localparam logic [TIME_W-1:0]  WINDOW_RESET = TIME_W'(64'd1000000000);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(100);

  typedef struct packed {
    logic               valid;
    logic [WAY_W-1:0]   age;
    logic [ADDR_W-1:0]  key;
    logic [TIME_W-1:0]  win_start;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef entry_t [TABLE_WAYS-1:0] row_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic             clear_we;
    logic [SET_W-1:0] clear_set;
    logic             load;
    logic             lookup;
    logic             update;
  } dp_cmd_t;

  // row written by the clearing pass: all ways invalid, ages in way order
  function automatic row_t clear_row();
    row_t r;
    for (int w = 0; w < TABLE_WAYS; w++) begin
      r[w].valid     = 1'b0;
      r[w].age       = WAY_W'(w);
      r[w].key       = '0;
      r[w].win_start = '0;
      r[w].count     = '0;
    end
    return r;
  endfunction

endpackage

@@ rtl/pswrl_cfg.sv @@
module pswrl_cfg
  import pswrl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic [TIME_W-1:0]     window_length_o,
  output logic [LIMIT_W-1:0]    default_limit_o
);

  logic [TIME_W-1:0]  window_length_q;
  logic [LIMIT_W-1:0] default_limit_q;

  assign cfg_ready_o = 1'b1;

  // writes to unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= WINDOW_RESET;
      default_limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_WINDOW_LENGTH) begin
        window_length_q <= cfg_data_i[TIME_W-1:0];
      end
      if (cfg_index_i == CFG_DEFAULT_LIMIT) begin
        default_limit_q <= cfg_data_i[LIMIT_W-1:0];
      end
    end
  end

  assign window_length_o = window_length_q;
  assign default_limit_o = default_limit_q;

endmodule

@@ rtl/pswrl_ctrl.sv @@
module pswrl_ctrl
  import pswrl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_UPDATE
  } state_e;

  state_e           state_q, state_d;
  logic [SET_W-1:0] clr_set_q, clr_set_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    clr_set_d   = clr_set_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.clear_set = clr_set_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_we = 1'b1;
        if (clr_set_q == SET_W'(TABLE_SETS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_set_d = clr_set_q + SET_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = S_UPDATE;
      end
      S_UPDATE: begin
        // hold the write-back until the result register has room
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.update = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_set_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_set_q   <= clr_set_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/pswrl_dp.sv @@
module pswrl_dp
  import pswrl_pkg::*;
(
  input  logic               clk_i,
  input  dp_cmd_t            cmd_i,
  input  logic [TIME_W-1:0]  window_length_i,
  input  logic [LIMIT_W-1:0] default_limit_i,
  input  logic               is_ipv4_i,
  input  logic [ADDR_W-1:0]  src_ip_i,
  input  logic [TIME_W-1:0]  now_ns_i,
  input  logic               override_valid_i,
  input  logic [LIMIT_W-1:0] override_limit_i,
  output logic               drop_o
);

  row_t mem [TABLE_SETS];

  logic               ipv4_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [TIME_W-1:0]  now_q;
  logic [LIMIT_W-1:0] limit_q;
  row_t               row_q;

  logic               hit_q, hit_d;
  logic [WAY_W-1:0]   way_q, way_d;
  logic [TIME_W-1:0]  elapsed_q;
  logic [COUNT_W-1:0] count_q;
  logic [TIME_W-1:0]  start_q;
  logic               drop_q;

  logic               free_found;
  logic [WAY_W-1:0]   hit_way, free_way, old_way;

  logic               restart;
  logic [COUNT_W-1:0] count_eff;
  logic               drop_d;
  logic [WAY_W-1:0]   touched_age;
  row_t               row_d;

  // lookup: tag match, else first free way, else least recently used
  always_comb begin
    hit_d      = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    old_way    = '0;
    for (int w = TABLE_WAYS - 1; w >= 0; w--) begin
      if (row_q[w].valid && row_q[w].key == addr_q) begin
        hit_d   = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!row_q[w].valid) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
      if (row_q[w].age == WAY_W'(TABLE_WAYS - 1)) begin
        old_way = WAY_W'(w);
      end
    end
    if (hit_d) begin
      way_d = hit_way;
    end else if (free_found) begin
      way_d = free_way;
    end else begin
      way_d = old_way;
    end
  end

  // update: window restart, verdict, lru ages and the new entry
  always_comb begin
    restart     = elapsed_q > window_length_i;
    count_eff   = restart ? '0 : count_q;
    drop_d      = hit_q && (count_eff >= COUNT_W'(limit_q));
    touched_age = row_q[way_q].age;
    row_d       = row_q;
    for (int w = 0; w < TABLE_WAYS; w++) begin
      if (row_q[w].age < touched_age) begin
        row_d[w].age = row_q[w].age + WAY_W'(1);
      end
    end
    row_d[way_q].age = '0;
    if (hit_q) begin
      row_d[way_q].win_start = restart ? now_q : start_q;
      row_d[way_q].count     = drop_d ? count_eff : count_eff + COUNT_W'(1);
    end else begin
      row_d[way_q].valid     = 1'b1;
      row_d[way_q].key       = addr_q;
      row_d[way_q].win_start = now_q;
      row_d[way_q].count     = COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_we) begin
      mem[cmd_i.clear_set] <= clear_row();
    end else if (cmd_i.update && ipv4_q) begin
      mem[addr_q[SET_W-1:0]] <= row_d;
    end
    if (cmd_i.load) begin
      row_q   <= mem[src_ip_i[SET_W-1:0]];
      ipv4_q  <= is_ipv4_i;
      addr_q  <= src_ip_i;
      now_q   <= now_ns_i;
      limit_q <= override_valid_i ? override_limit_i : default_limit_i;
    end
    if (cmd_i.lookup) begin
      hit_q     <= hit_d;
      way_q     <= way_d;
      count_q   <= row_q[way_d].count;
      start_q   <= row_q[way_d].win_start;
      elapsed_q <= now_q - row_q[way_d].win_start;
    end
    if (cmd_i.update) begin
      drop_q <= ipv4_q && drop_d;
    end
  end

  assign drop_o = drop_q;

endmodule

@@ rtl/per_source_window_rate_limiter.sv @@
// channel   direction  handshake              payload
// request   in         in_valid_i/in_stall_o  is_ipv4, src_ip, now_ns, override_*
// verdict   out        out_valid_o/out_stall_i drop
// config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// a request passes through table row read, lookup, then write-back and verdict, and a new
// one is taken only after that write-back, as the row memory (one set per row) is read-modify-written
// after reset a clearing pass over all TABLE_SETS (256) sets runs before requests are taken
// a stalled verdict holds the write-back of the next request until it is taken
// config writes are taken every cycle, also during the clearing pass
module per_source_window_rate_limiter
  import pswrl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  is_ipv4_i,
  input  logic [ADDR_W-1:0]     src_ip_i,
  input  logic [TIME_W-1:0]     now_ns_i,
  input  logic                  override_valid_i,
  input  logic [LIMIT_W-1:0]    override_limit_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  drop_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dp_cmd_t            cmd;
  logic [TIME_W-1:0]  window_length;
  logic [LIMIT_W-1:0] default_limit;

  pswrl_cfg u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .window_length_o (window_length),
    .default_limit_o (default_limit)
  );

  pswrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  pswrl_dp u_dp (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .window_length_i  (window_length),
    .default_limit_i  (default_limit),
    .is_ipv4_i        (is_ipv4_i),
    .src_ip_i         (src_ip_i),
    .now_ns_i         (now_ns_i),
    .override_valid_i (override_valid_i),
    .override_limit_i (override_limit_i),
    .drop_o           (drop_o)
  );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import pswrl_pkg::*;

  localparam int DEPTH = TABLE_SETS * TABLE_WAYS;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES = 6;
  localparam int PHASE_REQUESTS = 100;
  localparam int LONG_HOLD_AT = 150;
  localparam int LONG_HOLD_CYCLES = 80;
  // index with no register behind it, writes are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(2);

  typedef struct {
    logic               is_ipv4;
    logic [ADDR_W-1:0]  addr;
    logic [TIME_W-1:0]  now;
    logic               ovr_valid;
    logic [LIMIT_W-1:0] ovr_limit;
  } pkt_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  is_ipv4_i = 1'b0;
  logic [ADDR_W-1:0]     src_ip_i = '0;
  logic [TIME_W-1:0]     now_ns_i = '0;
  logic                  override_valid_i = 1'b0;
  logic [LIMIT_W-1:0]    override_limit_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  drop_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // shadow of the register file and the source table
  logic [TIME_W-1:0]  cfg_window;
  logic [LIMIT_W-1:0] cfg_limit;
  logic               tbl_valid [DEPTH];
  logic [ADDR_W-1:0]  tbl_key [DEPTH];
  logic [TIME_W-1:0]  tbl_start [DEPTH];
  logic [COUNT_W-1:0] tbl_count [DEPTH];
  logic [WAY_W-1:0]   tbl_age [DEPTH];

  pkt_t pending_q [$];
  logic verdict_q [$];
  pkt_t cur_pkt;
  logic want_drop;
  logic no_idle = 1'b0;
  int   tx_wait = 0;
  int   rx_wait = 0;
  int   verdicts_seen = 0;
  int   quiet_cycles = 0;
  int   fail_count = 0;

  // random traffic shaping
  logic [TIME_W-1:0] t_now;
  int                step_max;
  logic [23:0]       hi_pool [6];
  logic [7:0]        set_pool [3];

  always #10 clk_i = ~clk_i;

  per_source_window_rate_limiter DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .is_ipv4_i(is_ipv4_i),
    .src_ip_i(src_ip_i),
    .now_ns_i(now_ns_i),
    .override_valid_i(override_valid_i),
    .override_limit_i(override_limit_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .drop_o(drop_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  function automatic void clear_table();
    cfg_window = WINDOW_RESET;
    cfg_limit  = LIMIT_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_start[i] = '0;
      tbl_count[i] = '0;
      tbl_age[i]   = WAY_W'(i % TABLE_WAYS);
    end
  endfunction

  // make a way the most recent, the ways that were newer age by one
  function automatic void touch_way(int base, int way);
    logic [WAY_W-1:0] old;
    old = tbl_age[base + way];
    for (int i = 0; i < TABLE_WAYS; i++)
      if (tbl_age[base + i] < old) tbl_age[base + i] = tbl_age[base + i] + 1'b1;
    tbl_age[base + way] = '0;
  endfunction

  // verdict for one request, updates the shadow table
  function automatic logic rate_verdict(pkt_t p);
    logic [LIMIT_W-1:0] lim;
    logic               hit;
    logic               found_free;
    logic [WAY_W-1:0]   oldest;
    int                 base;
    int                 way;
    int                 idx;
    if (!p.is_ipv4) return 1'b0;
    lim  = p.ovr_valid ? p.ovr_limit : cfg_limit;
    base = int'(p.addr % TABLE_SETS) * TABLE_WAYS;
    hit  = 1'b0;
    way  = 0;
    for (int w = TABLE_WAYS - 1; w >= 0; w--)
      if (tbl_valid[base + w] && tbl_key[base + w] == p.addr) begin
        hit = 1'b1;
        way = w;
      end
    if (hit) begin
      idx = base + way;
      if (p.now - tbl_start[idx] > cfg_window) begin
        tbl_start[idx] = p.now;
        tbl_count[idx] = '0;
      end
      touch_way(base, way);
      if (tbl_count[idx] >= lim) return 1'b1;
      tbl_count[idx] = tbl_count[idx] + 1'b1;
      return 1'b0;
    end
    found_free = 1'b0;
    for (int w = TABLE_WAYS - 1; w >= 0; w--)
      if (!tbl_valid[base + w]) begin
        found_free = 1'b1;
        way = w;
      end
    if (!found_free) begin
      oldest = '0;
      for (int w = 0; w < TABLE_WAYS; w++)
        if (tbl_age[base + w] >= oldest) begin
          oldest = tbl_age[base + w];
          way = w;
        end
    end
    idx = base + way;
    tbl_valid[idx] = 1'b1;
    tbl_key[idx]   = p.addr;
    tbl_start[idx] = p.now;
    tbl_count[idx] = COUNT_W'(1);
    touch_way(base, way);
    return 1'b0;
  endfunction

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic pkt_t mk_pkt(logic ip4, logic [ADDR_W-1:0] a, logic [TIME_W-1:0] t,
                                  logic ov, logic [LIMIT_W-1:0] lim);
    pkt_t p;
    p.is_ipv4   = ip4;
    p.addr      = a;
    p.now       = t;
    p.ovr_valid = ov;
    p.ovr_limit = lim;
    return p;
  endfunction

  // mostly well-formed traffic on a few crowded sets, some noise
  function automatic pkt_t gen_pkt();
    pkt_t p;
    int   r;
    r = $urandom_range(0, 99);
    if (r < 5) t_now = {$urandom, $urandom};
    else if (r < 10) t_now = t_now - $urandom_range(0, step_max);
    else t_now = t_now + $urandom_range(0, step_max);
    p.is_ipv4   = 1'b1;
    p.addr      = {hi_pool[$urandom_range(0, 5)], set_pool[$urandom_range(0, 2)]};
    p.now       = t_now;
    p.ovr_valid = ($urandom_range(0, 3) == 0);
    p.ovr_limit = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 6);
    if (r >= 90) begin
      p.is_ipv4   = 1'($urandom_range(0, 1));
      p.addr      = $urandom;
      p.now       = {$urandom, $urandom};
      p.ovr_valid = 1'($urandom_range(0, 1));
      p.ovr_limit = $urandom;
    end
    return p;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_WINDOW_LENGTH) cfg_window = val;
    else if (idx == CFG_DEFAULT_LIMIT) cfg_limit = val[LIMIT_W-1:0];
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || verdict_q.size() != 0);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        verdict_q.push_back(rate_verdict(cur_pkt));
        tx_wait = draw_wait();
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_pkt = pending_q.pop_front();
          in_valid_i       <= 1'b1;
          is_ipv4_i        <= cur_pkt.is_ipv4;
          src_ip_i         <= cur_pkt.addr;
          now_ns_i         <= cur_pkt.now;
          override_valid_i <= cur_pkt.ovr_valid;
          override_limit_i <= cur_pkt.ovr_limit;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // verdict monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          $display("%0t: verdict expected none actual drop=%0b", $time, drop_o);
          fail_count++;
        end else begin
          want_drop = verdict_q.pop_front();
          if (drop_o !== want_drop) begin
            $display("%0t: drop expected %0b actual %0b", $time, want_drop, drop_o);
            fail_count++;
          end
        end
        // one long hold-off so the block backs up into the request side
        rx_wait = (verdicts_seen == LONG_HOLD_AT) ? LONG_HOLD_CYCLES : draw_wait();
      end
      if (rx_wait > 0) begin
        out_stall_i <= 1'b1;
        rx_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("per_source_window_rate_limiter: mismatch");
      $finish;
    end
  end

  initial begin
    logic [TIME_W-1:0]  win_set [PHASES];
    logic [LIMIT_W-1:0] lim_set [PHASES];
    logic [ADDR_W-1:0]  a_key;
    logic [ADDR_W-1:0]  b_key;
    logic [ADDR_W-1:0]  c_key;
    logic [ADDR_W-1:0]  d_key;
    logic [ADDR_W-1:0]  e_key;
    win_set = '{64'd1, '1, 64'd500, 64'd200, WINDOW_RESET, 64'd50};
    lim_set = '{32'd0, 32'd3, '1, 32'd4, LIMIT_RESET, 32'd1};
    a_key = 32'h0000_0010;
    b_key = 32'h0100_0010;
    c_key = 32'h0200_0010;
    d_key = 32'h0300_0010;
    e_key = 32'h0400_0010;
    clear_table();
    foreach (hi_pool[k]) hi_pool[k] = 24'($urandom);
    foreach (set_pool[k]) set_pool[k] = 8'($urandom);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(CFG_WINDOW_LENGTH, 64'd100);
    write_reg(CFG_DEFAULT_LIMIT, 64'd2);
    pending_q.push_back(mk_pkt(1'b0, '1, '1, 1'b1, '1));
    pending_q.push_back(mk_pkt(1'b1, a_key, 64'd1000, 1'b0, '0));
    pending_q.push_back(mk_pkt(1'b1, a_key, 64'd1010, 1'b0, '0));
    pending_q.push_back(mk_pkt(1'b1, a_key, 64'd1020, 1'b0, '0));
    // exactly one window later: no restart yet
    pending_q.push_back(mk_pkt(1'b1, a_key, 64'd1100, 1'b0, '0));
    pending_q.push_back(mk_pkt(1'b1, a_key, 64'd1101, 1'b0, '0));
    pending_q.push_back(mk_pkt(1'b1, a_key, 64'd1102, 1'b1, '0));
    pending_q.push_back(mk_pkt(1'b1, a_key, 64'd1103, 1'b1, '1));
    pending_q.push_back(mk_pkt(1'b1, b_key, 64'd1104, 1'b0, '0));
    pending_q.push_back(mk_pkt(1'b1, c_key, 64'd1105, 1'b0, '0));
    pending_q.push_back(mk_pkt(1'b1, d_key, 64'd1106, 1'b0, '0));
    // dropped hit still refreshes lru, so b is evicted next
    pending_q.push_back(mk_pkt(1'b1, a_key, 64'd1107, 1'b0, '0));
    pending_q.push_back(mk_pkt(1'b1, e_key, 64'd1108, 1'b0, '0));
    pending_q.push_back(mk_pkt(1'b1, b_key, 64'd1109, 1'b0, '0));
    pending_q.push_back(mk_pkt(1'b1, c_key, 64'd1110, 1'b1, '0));
    pending_q.push_back(mk_pkt(1'b1, '0, '0, 1'b1, '0));
    // time wraps past zero inside one window, then jumps backwards
    pending_q.push_back(mk_pkt(1'b1, '1, 64'hFFFF_FFFF_FFFF_FFFB, 1'b0, '0));
    pending_q.push_back(mk_pkt(1'b1, '1, 64'd10, 1'b0, '0));
    pending_q.push_back(mk_pkt(1'b1, '1, 64'd20, 1'b0, '0));
    pending_q.push_back(mk_pkt(1'b1, '1, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0, '0));
    pending_q.push_back(mk_pkt(1'b0, '0, '0, 1'b0, '0));
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(CFG_WINDOW_LENGTH, win_set[ph]);
      write_reg(CFG_DEFAULT_LIMIT, CFG_DATA_W'(lim_set[ph]));
      if (ph == 2) write_reg(CFG_SPARE, {$urandom, $urandom});
      no_idle  = (ph % 3 == 1);
      step_max = (win_set[ph] <= 4) ? 3 : (win_set[ph] > 3000) ? 400 : int'(win_set[ph] / 3);
      t_now    = (ph == 1) ? 64'hFFFF_FFFF_FFFF_F000 : {$urandom, $urandom};
      repeat (PHASE_REQUESTS) pending_q.push_back(gen_pkt());
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && verdict_q.size() == 0)
      $display("per_source_window_rate_limiter: match");
    else
      $display("per_source_window_rate_limiter: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pswrl_pkg.sv
rtl/pswrl_cfg.sv
rtl/pswrl_ctrl.sv
rtl/pswrl_dp.sv
rtl/per_source_window_rate_limiter.sv
bench/testbench.sv
